// File: hdl/htip_pkg.sv
// Shared types, codes and character helpers of the hex text image parser.
package htip_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] byte_address;
		logic [7:0]  data_byte;
		logic        last_of_line;
		logic        file_done;
	} result_t;

	localparam logic [1:0] K_DATA   = 2'd0;
	localparam logic [1:0] K_END    = 2'd1;
	localparam logic [1:0] K_DIGITS = 2'd2;
	localparam logic [1:0] K_BYTES  = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;

	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		PH_START,
		PH_AT,
		PH_HEX,
		PH_TRAIL,
		PH_FAIL
	} addr_phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLOSE,
		S_DECIDE,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       take;
		logic       close;
		logic       commit_addr;
		logic       load_kind;
		logic [1:0] kind;
		logic       set_halt;
		logic       start_read;
		logic       next_read;
		logic       advance;
		logic       end_line;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       halted;
		logic       item_eoi;
		logic       item_newline;
		logic       addr_line;
		logic       data_line;
		logic [1:0] err;
		logic       count_zero;
		logic       emit_last;
		logic       final_line;
		logic       kind_is_data;
	} dp_status_t;

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// File: hdl/htip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/htip_datapath.sv
// Line state, byte buffer, load address and result payload of the parser.
module htip_datapath #(
	parameter int MAX_LINE_BYTES = 64,
	parameter int ADDRESS_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  htip_pkg::item_t     item,
	input  htip_pkg::ctrl_cmd_t cmd,
	output htip_pkg::dp_status_t status,
	output htip_pkg::result_t   result
);
	import htip_pkg::*;

	localparam int CW = $clog2(MAX_LINE_BYTES + 1);
	localparam int IW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int AB = ADDRESS_BITS;

	logic [CW-1:0] count_q, n_count;
	logic [7:0]    value_q, n_value;
	logic [1:0]    digits_q, n_digits;
	logic [AB-1:0] load_q, n_load;
	logic [AB-1:0] laddr_q, n_laddr;
	addr_phase_t   phase_q, n_phase;
	logic          is_data_q, n_is_data;
	logic [1:0]    err_q, n_err;
	logic          halted_q, n_halted;
	logic          final_q, n_final;
	logic [1:0]    kind_q, n_kind;
	logic          done_q, n_done;
	logic [IW-1:0] idx_q, n_idx;

	logic          we, re;
	logic [IW-1:0] raddr;
	logic [7:0]    rdata;
	logic          do_close;
	logic [4:0]    hd;
	logic          sp;
	logic          feed;
	logic          emit_last;
	logic [AB-1:0] emit_addr;

	assign hd   = hex_digit(item.character);
	assign sp   = is_space(item.character);
	assign feed = cmd.take && !item.end_of_input && !halted_q;

	always_comb begin
		n_count   = count_q;
		n_value   = value_q;
		n_digits  = digits_q;
		n_load    = load_q;
		n_laddr   = laddr_q;
		n_phase   = phase_q;
		n_is_data = is_data_q;
		n_err     = err_q;
		n_halted  = halted_q;
		n_final   = final_q;
		n_kind    = kind_q;
		n_done    = done_q;
		n_idx     = idx_q;
		we        = 1'b0;
		re        = 1'b0;
		raddr     = idx_q;
		do_close  = 1'b0;

		if (cmd.take) begin
			n_final = item.end_of_input;
		end

		if (feed) begin
			case (phase_q) inside
				PH_START: begin
					n_phase = (item.character == CH_AT) ? PH_AT : PH_FAIL;
				end
				PH_AT, PH_HEX: begin
					if (hd[4]) begin
						n_laddr = {laddr_q[AB-5:0], hd[3:0]};
						n_phase = PH_HEX;
					end else if (sp && phase_q == PH_HEX) begin
						n_phase = PH_TRAIL;
					end else begin
						n_phase = PH_FAIL;
					end
				end
				PH_TRAIL: begin
					if (!sp) begin
						n_phase = PH_FAIL;
					end
				end
				default: begin
				end
			endcase

			if (is_data_q) begin
				if (sp) begin
					do_close = 1'b1;
				end else if (!hd[4]) begin
					n_is_data = 1'b0;
				end else if (err_q == ERR_NONE) begin
					if (digits_q >= 2'd2) begin
						n_err = K_DIGITS;
					end else begin
						n_value  = {value_q[3:0], hd[3:0]};
						n_digits = digits_q + 2'd1;
					end
				end
			end
		end

		if (cmd.close && is_data_q) begin
			do_close = 1'b1;
		end

		if (do_close) begin
			if (digits_q != 2'd0 && err_q == ERR_NONE) begin
				if (count_q >= CW'(MAX_LINE_BYTES)) begin
					n_err = K_BYTES;
				end else begin
					we      = 1'b1;
					n_count = count_q + CW'(1);
				end
			end
			n_digits = 2'd0;
			n_value  = 8'd0;
		end

		if (cmd.commit_addr) begin
			n_load = laddr_q;
		end
		if (cmd.set_halt) begin
			n_halted = 1'b1;
		end
		if (cmd.load_kind) begin
			n_kind = cmd.kind;
			n_done = final_q || cmd.kind == K_DIGITS || cmd.kind == K_BYTES;
		end
		if (cmd.start_read) begin
			n_idx = '0;
			re    = 1'b1;
			raddr = '0;
		end
		if (cmd.next_read) begin
			n_idx = idx_q + IW'(1);
			re    = 1'b1;
			raddr = idx_q + IW'(1);
		end
		if (cmd.advance) begin
			n_load = load_q + AB'(count_q);
		end

		// A line end clears the line; the end of the file, or an end of input
		// that arrives while halted, also clears the load address and the halt flag.
		if (cmd.end_line || (cmd.take && item.end_of_input && halted_q)) begin
			n_count   = '0;
			n_value   = 8'd0;
			n_digits  = 2'd0;
			n_laddr   = '0;
			n_phase   = PH_START;
			n_is_data = 1'b1;
			n_err     = ERR_NONE;
			if (final_q || cmd.take) begin
				n_load   = '0;
				n_halted = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			value_q   <= 8'd0;
			digits_q  <= 2'd0;
			load_q    <= '0;
			laddr_q   <= '0;
			phase_q   <= PH_START;
			is_data_q <= 1'b1;
			err_q     <= ERR_NONE;
			halted_q  <= 1'b0;
			final_q   <= 1'b0;
			kind_q    <= K_DATA;
			done_q    <= 1'b0;
			idx_q     <= '0;
		end else begin
			count_q   <= n_count;
			value_q   <= n_value;
			digits_q  <= n_digits;
			load_q    <= n_load;
			laddr_q   <= n_laddr;
			phase_q   <= n_phase;
			is_data_q <= n_is_data;
			err_q     <= n_err;
			halted_q  <= n_halted;
			final_q   <= n_final;
			kind_q    <= n_kind;
			done_q    <= n_done;
			idx_q     <= n_idx;
		end
	end

	htip_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LINE_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (we),
		.waddr(count_q[IW-1:0]),
		.wdata(value_q),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign emit_last = (kind_q != K_DATA) || (CW'(idx_q) == count_q - CW'(1));
	assign emit_addr = load_q + AB'(idx_q);

	assign result.kind         = kind_q;
	assign result.byte_address = (kind_q == K_DATA) ? 32'(emit_addr) : 32'd0;
	assign result.data_byte    = (kind_q == K_DATA) ? rdata : 8'd0;
	assign result.last_of_line = emit_last;
	assign result.file_done    = emit_last && done_q;

	assign status.halted       = halted_q;
	assign status.item_eoi     = item.end_of_input;
	assign status.item_newline = item.character == CH_NEWLINE;
	assign status.addr_line    = phase_q == PH_HEX || phase_q == PH_TRAIL;
	assign status.data_line    = is_data_q;
	assign status.err          = err_q;
	assign status.count_zero   = count_q == '0;
	assign status.emit_last    = emit_last;
	assign status.final_line   = final_q;
	assign status.kind_is_data = kind_q == K_DATA;

endmodule

// File: hdl/htip_ctrl.sv
// Sequencing state machine: takes characters, closes lines and paces result beats.
module htip_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 result_ready,
	input  htip_pkg::dp_status_t status,
	output htip_pkg::ctrl_cmd_t  cmd,
	output logic                 item_ready,
	output logic                 result_valid
);
	import htip_pkg::*;

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid && !status.halted && (status.item_eoi || status.item_newline)) begin
					state_n = S_CLOSE;
				end
			end
			S_CLOSE: begin
				state_n = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.addr_line) begin
					state_n = status.final_line ? S_EMIT : S_IDLE;
				end else if (status.data_line && (status.err != ERR_NONE || !status.count_zero)) begin
					state_n = S_EMIT;
				end else begin
					state_n = status.final_line ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (result_ready && status.emit_last) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		item_ready   = 1'b0;
		result_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				cmd.take   = item_valid;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
			end
			S_DECIDE: begin
				if (status.addr_line) begin
					cmd.commit_addr = 1'b1;
					if (status.final_line) begin
						cmd.load_kind = 1'b1;
						cmd.kind      = K_END;
					end else begin
						cmd.end_line = 1'b1;
					end
				end else if (status.data_line && status.err != ERR_NONE) begin
					cmd.load_kind = 1'b1;
					cmd.kind      = status.err;
					cmd.set_halt  = 1'b1;
				end else if (status.data_line && !status.count_zero) begin
					cmd.load_kind  = 1'b1;
					cmd.kind       = K_DATA;
					cmd.start_read = 1'b1;
				end else if (status.final_line) begin
					cmd.load_kind = 1'b1;
					cmd.kind      = K_END;
				end else begin
					cmd.end_line = 1'b1;
				end
			end
			S_EMIT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					if (status.emit_last) begin
						cmd.end_line = 1'b1;
						cmd.advance  = status.kind_is_data;
					end else begin
						cmd.next_read = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/hex_text_image_parser_top.sv
// Top level of the hex text image parser: controller plus datapath.
// Characters that do not end a line are taken back to back while the controller is idle.
// A newline or end of input, unless halted, moves through S_CLOSE and S_DECIDE to close and sort
// the line, then S_EMIT gives one result beat per cycle while result_ready is high, data beats
// read from the line buffer RAM port.
// Reset is asynchronous and clears all control state; the line buffer needs no clearing.
module hex_text_image_parser_top #(
	parameter int MAX_LINE_BYTES = 64,
	parameter int ADDRESS_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  htip_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output htip_pkg::result_t result
);
	import htip_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	htip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.result_ready(result_ready),
		.status      (status),
		.cmd         (cmd),
		.item_ready  (item_ready),
		.result_valid(result_valid)
	);

	htip_datapath #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES),
		.ADDRESS_BITS  (ADDRESS_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.status(status),
		.result(result)
	);

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the hex text image parser: directed rows and sequences, then random text files.
module testbench;
	import htip_pkg::*;

	localparam int MAX_BYTES   = 64;
	localparam int ITEM_TARGET = 430;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 600;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_VTAB     = 8'h0B;
	localparam logic [7:0] CH_FORMFEED = 8'h0C;
	localparam logic [7:0] CH_RETURN   = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	localparam result_t NO_BEAT = '0;

	typedef struct {
		item_t   beat_in;
		bit      typed;
		result_t typed_out;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// Parser image held by the predictor.
	logic [7:0]  line_bytes [MAX_BYTES];
	int          line_fill;
	logic [7:0]  digit_acc;
	int          digit_run;
	logic [31:0] next_addr;
	logic [31:0] addr_acc;
	addr_phase_t addr_phase;
	bit          data_ok;
	logic [1:0]  line_fault;
	bit          stopped;

	result_t new_beats [$];
	result_t expected_beats [$];
	int      fail_count;
	int      beats_checked;
	int      live_items;
	bit      steady;
	bit      long_hold_done;

	stim_row_t directed_rows [0:23];

	hex_text_image_parser_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int nibble_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
		return -1;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FORMFEED, CH_RETURN};
	endfunction

	function automatic void clear_line();
		line_fill = 0;
		digit_acc = '0;
		digit_run = 0;
		addr_acc = '0;
		addr_phase = PH_START;
		data_ok = 1'b1;
		line_fault = ERR_NONE;
	endfunction

	function automatic void restart_file();
		next_addr = '0;
		stopped = 1'b0;
		clear_line();
	endfunction

	function automatic void commit_group();
		if (digit_run != 0 && line_fault == ERR_NONE) begin
			if (line_fill >= MAX_BYTES) begin
				line_fault = K_BYTES;
			end else begin
				line_bytes[line_fill] = digit_acc;
				line_fill++;
			end
		end
		digit_run = 0;
		digit_acc = '0;
	endfunction

	function automatic void flush_line(bit file_end);
		result_t beat;
		bit      done;
		done = file_end;
		if (data_ok) commit_group();
		if (addr_phase == PH_HEX || addr_phase == PH_TRAIL) begin
			next_addr = addr_acc;
		end else if (data_ok) begin
			if (line_fault != ERR_NONE) begin
				beat = '0;
				beat.kind = line_fault;
				new_beats.push_back(beat);
				stopped = 1'b1;
				done = 1'b1;
			end else begin
				for (int i = 0; i < line_fill; i++) begin
					beat = '0;
					beat.kind = K_DATA;
					beat.byte_address = next_addr + 32'(i);
					beat.data_byte = line_bytes[i];
					new_beats.push_back(beat);
				end
				next_addr = next_addr + 32'(line_fill);
			end
		end
		if (file_end && new_beats.size() == 0) begin
			beat = '0;
			beat.kind = K_END;
			new_beats.push_back(beat);
		end
		if (new_beats.size() > 0) begin
			beat = new_beats.pop_back();
			beat.last_of_line = 1'b1;
			beat.file_done = done;
			new_beats.push_back(beat);
		end
		clear_line();
	endfunction

	// Advances the parser image by one accepted beat and leaves its results in new_beats.
	function automatic void absorb_item(item_t beat_in);
		logic [7:0] c;
		int         nib;
		bit         sp;
		new_beats.delete();
		if (beat_in.end_of_input) begin
			if (!stopped) flush_line(1'b1);
			restart_file();
			return;
		end
		if (stopped) return;
		c = beat_in.character;
		nib = nibble_of(c);
		sp = is_blank(c);
		case (addr_phase)
			PH_START: addr_phase = (c == CH_AT) ? PH_AT : PH_FAIL;
			PH_AT, PH_HEX: begin
				if (nib >= 0) begin
					addr_acc = {addr_acc[27:0], nib[3:0]};
					addr_phase = PH_HEX;
				end else if (sp && addr_phase == PH_HEX) begin
					addr_phase = PH_TRAIL;
				end else begin
					addr_phase = PH_FAIL;
				end
			end
			PH_TRAIL: if (!sp) addr_phase = PH_FAIL;
			default: ;
		endcase
		if (data_ok) begin
			if (sp) begin
				commit_group();
			end else if (nib < 0) begin
				data_ok = 1'b0;
			end else if (line_fault == ERR_NONE) begin
				if (digit_run >= 2) begin
					line_fault = K_DIGITS;
				end else begin
					digit_acc = {digit_acc[3:0], nib[3:0]};
					digit_run++;
				end
			end
		end
		if (c == CH_NEWLINE) flush_line(1'b0);
	endfunction

	// Mostly no gap, some short ones, a few long ones; none in a steady stretch.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 7))
			0: return CH_TAB;
			1: return CH_VTAB;
			2: return CH_FORMFEED;
			3: return CH_RETURN;
			default: return CH_SPACE;
		endcase
	endfunction

	task automatic send_item(item_t beat_in, bit typed, result_t typed_out);
		int gap;
		live_items++;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= beat_in;
		do @(posedge clk); while (!item_ready);
		absorb_item(beat_in);
		if (typed) begin
			expected_beats.push_back(typed_out);
		end else begin
			foreach (new_beats[i]) expected_beats.push_back(new_beats[i]);
		end
	endtask

	task automatic send_char(logic [7:0] c);
		send_item(item_t'{c, 1'b0}, 1'b0, NO_BEAT);
	endtask

	task automatic send_eof();
		send_item(item_t'{8'($urandom_range(0, 255)), 1'b1}, 1'b0, NO_BEAT);
	endtask

	// Groups of hex digits split by whitespace; faults add stray bytes and long groups.
	task automatic send_data_line(int groups, int max_digits, int fault_pct, bit ends_file);
		int digits;
		if (max_digits > 1 && $urandom_range(0, 3) == 0) send_char(blank_char());
		repeat (groups) begin
			digits = ($urandom_range(0, 99) < fault_pct) ? 3 : $urandom_range(1, max_digits);
			if ($urandom_range(0, 99) < fault_pct) send_char(8'($urandom_range(0, 255)));
			repeat (digits) send_char(hex_char());
			send_char(blank_char());
			if (max_digits > 1 && $urandom_range(0, 4) == 0) send_char(blank_char());
		end
		if (ends_file) send_eof();
		else send_char(CH_NEWLINE);
	endtask

	task automatic send_addr_line(int digits, bit broken);
		send_char(CH_AT);
		repeat (digits) send_char(hex_char());
		if (broken) send_char(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 2) == 0) send_char(blank_char());
		send_char(CH_NEWLINE);
	endtask

	always @(posedge clk) begin : check_beat
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat: kind %0d addr %h data %h", result.kind,
					result.byte_address, result.data_byte);
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					fail_count++;
				end
				if (result.byte_address !== want.byte_address) begin
					$error("byte_address: expected %h, got %h", want.byte_address,
						result.byte_address);
					fail_count++;
				end
				if (result.data_byte !== want.data_byte) begin
					$error("data_byte: expected %h, got %h", want.data_byte, result.data_byte);
					fail_count++;
				end
				if (result.last_of_line !== want.last_of_line) begin
					$error("last_of_line: expected %0b, got %0b", want.last_of_line,
						result.last_of_line);
					fail_count++;
				end
				if (result.file_done !== want.file_done) begin
					$error("file_done: expected %0b, got %0b", want.file_done, result.file_done);
					fail_count++;
				end
			end
		end
	end

	// Alternate between stretches with random gaps and stretches without any.
	always @(posedge clk) begin : pacing
		if ($urandom_range(0, 399) == 0) steady <= ~steady;
	end

	initial begin : receiver
		int stall;
		stall = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			// One long hold-off while a full line is draining, so the input side backs up.
			if (!long_hold_done && beats_checked >= 40) begin
				long_hold_done = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				stall = idle_len();
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int roll;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		steady = 1'b0;
		long_hold_done = 1'b0;
		fail_count = 0;
		beats_checked = 0;
		live_items = 0;
		restart_file();
		directed_rows = '{
			// End of file straight after reset: a lone end marker.
			'{item_t'{8'hFF, 1'b1}, 1'b1, result_t'{K_END, 32'd0, 8'd0, 1'b1, 1'b1}},
			// Address line with trailing tab.
			'{item_t'{CH_AT, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h61, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_TAB, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_NEWLINE, 1'b0}, 1'b0, NO_BEAT},
			// Data line: one-digit group, upper and lower case, carriage return.
			'{item_t'{8'h66, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_SPACE, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h46, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h30, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_RETURN, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_NEWLINE, 1'b0}, 1'b0, NO_BEAT},
			// Three-digit group stops the file.
			'{item_t'{8'h31, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h32, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h33, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_NEWLINE, 1'b0}, 1'b1, result_t'{K_DIGITS, 32'd0, 8'd0, 1'b1, 1'b1}},
			// Ignored while stopped, then a silent restart.
			'{item_t'{8'h5A, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h00, 1'b1}, 1'b0, NO_BEAT},
			// Digit fault on a line that turns out not to be data is dropped.
			'{item_t'{8'h37, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h37, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h37, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h47, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{CH_NEWLINE, 1'b0}, 1'b0, NO_BEAT},
			// Unterminated line flushed by end of file.
			'{item_t'{8'h39, 1'b0}, 1'b0, NO_BEAT},
			'{item_t'{8'h00, 1'b1}, 1'b1, result_t'{K_DATA, 32'd0, 8'h09, 1'b1, 1'b1}}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].beat_in, directed_rows[i].typed, directed_rows[i].typed_out);

		// Address past 32 bits, then a full line that wraps the address, then one byte too many.
		send_char(CH_AT);
		send_char(8'h31);
		repeat (7) send_char(8'h46);
		send_char(8'h45);
		send_char(CH_NEWLINE);
		send_data_line(MAX_BYTES, 1, 0, 1'b0);
		send_data_line(MAX_BYTES + 1, 1, 0, 1'b0);
		send_eof();

		while (live_items < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (stopped) begin
				if (roll < 30) send_char(8'($urandom_range(0, 255)));
				else send_eof();
			end else if (roll < 42) begin
				send_data_line($urandom_range(0, 6), 2, 0, 1'b0);
			end else if (roll < 52) begin
				send_data_line($urandom_range(1, 5), 2, 12, 1'b0);
			end else if (roll < 68) begin
				send_addr_line($urandom_range(0, 10), $urandom_range(0, 9) == 0);
			end else if (roll < 80) begin
				repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
				send_char(CH_NEWLINE);
			end else if (roll < 90) begin
				send_data_line($urandom_range(0, 4), 2, 5, 1'b1);
			end else begin
				send_eof();
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/htip_pkg.sv
hdl/htip_ram.sv
hdl/htip_datapath.sv
hdl/htip_ctrl.sv
hdl/hex_text_image_parser_top.sv
verif/testbench.sv
